// File: rtl/c8080_pkg.sv
// ----------------------------------------------------------------------------
// c8080_pkg
// Shared types and constants for the 8080 subset execute block: opcodes,
// register select codes, flag bit positions and the state/result records.
// ----------------------------------------------------------------------------
package c8080_pkg;

  // Opcodes outside the MOV/ADD/SUB groups
  localparam logic [7:0] OP_NOP  = 8'h00;
  localparam logic [7:0] OP_LXIB = 8'h01;
  localparam logic [7:0] OP_ADI  = 8'hc6;
  localparam logic [7:0] OP_SUI  = 8'hd6;
  localparam logic [7:0] OP_JMP  = 8'hc3;
  localparam logic [7:0] OP_JNZ  = 8'hc2;
  localparam logic [7:0] OP_JZ   = 8'hca;
  localparam logic [7:0] OP_JNC  = 8'hd2;
  localparam logic [7:0] OP_JC   = 8'hda;
  localparam logic [7:0] OP_JP   = 8'hf2;
  localparam logic [7:0] OP_CALL = 8'hcd;
  localparam logic [7:0] OP_RET  = 8'hc9;

  // Group prefixes in the upper opcode bits
  localparam logic [1:0] GRP_MOV = 2'b01;
  localparam logic [4:0] GRP_ADD = 5'b10000;
  localparam logic [4:0] GRP_SUB = 5'b10010;

  // Register select field codes
  localparam logic [2:0] REG_B = 3'd0;
  localparam logic [2:0] REG_C = 3'd1;
  localparam logic [2:0] REG_D = 3'd2;
  localparam logic [2:0] REG_E = 3'd3;
  localparam logic [2:0] REG_H = 3'd4;
  localparam logic [2:0] REG_L = 3'd5;
  localparam logic [2:0] REG_M = 3'd6;
  localparam logic [2:0] REG_A = 3'd7;

  // Flag bit positions
  localparam int FLAG_Z = 0;
  localparam int FLAG_S = 1;
  localparam int FLAG_P = 2;
  localparam int FLAG_C = 3;

  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  d;
    logic [7:0]  e;
    logic [7:0]  h;
    logic [7:0]  l;
    logic [15:0] sp;
    logic [15:0] pc;
    logic [3:0]  flags;
  } arch_state_t;

  typedef struct packed {
    logic        wr_en;
    logic [15:0] wr_addr;
    logic [15:0] wr_word;
    logic        fault;
  } exec_status_t;

  typedef struct packed {
    logic [7:0]  op_code;
    logic [7:0]  imm_low;
    logic [7:0]  imm_high;
    logic [7:0]  mem_byte;
    logic [15:0] stack_word;
  } in_payload_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [7:0]  acc_value;
    logic [3:0]  flag_bits;
    logic [15:0] pair_bc;
    logic [15:0] pair_de;
    logic [15:0] pair_hl;
    logic [15:0] stack_ptr;
    logic        write_enable;
    logic [15:0] write_addr;
    logic [15:0] write_word;
    logic        fault;
  } out_payload_t;

endpackage

// File: rtl/c8080_if.sv
// ----------------------------------------------------------------------------
// c8080 channel interfaces
// Valid/ready channels for instruction items and execute results.
// ----------------------------------------------------------------------------
interface c8080_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  op_code;
  logic [7:0]  imm_low;
  logic [7:0]  imm_high;
  logic [7:0]  mem_byte;
  logic [15:0] stack_word;

  modport source (
    output valid, op_code, imm_low, imm_high, mem_byte, stack_word,
    input  ready
  );
  modport sink (
    input  valid, op_code, imm_low, imm_high, mem_byte, stack_word,
    output ready
  );
endinterface

interface c8080_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic [7:0]  acc_value;
  logic [3:0]  flag_bits;
  logic [15:0] pair_bc;
  logic [15:0] pair_de;
  logic [15:0] pair_hl;
  logic [15:0] stack_ptr;
  logic        write_enable;
  logic [15:0] write_addr;
  logic [15:0] write_word;
  logic        fault;

  modport source (
    output valid, next_pc, acc_value, flag_bits, pair_bc, pair_de, pair_hl,
           stack_ptr, write_enable, write_addr, write_word, fault,
    input  ready
  );
  modport sink (
    input  valid, next_pc, acc_value, flag_bits, pair_bc, pair_de, pair_hl,
           stack_ptr, write_enable, write_addr, write_word, fault,
    output ready
  );
endinterface

// File: rtl/c8080_alu.sv
// ----------------------------------------------------------------------------
// c8080_alu
// 8-bit add/subtract with Z, S, P and CY flag generation.
// ----------------------------------------------------------------------------
module c8080_alu (
  input  logic [7:0] acc,
  input  logic [7:0] operand,
  input  logic       sub,
  output logic [7:0] result,
  output logic [3:0] flags
);

  logic [8:0] sum9;

  // Bit 8 is carry for add and borrow (operand > acc) for subtract
  assign sum9   = sub ? ({1'b0, acc} - {1'b0, operand})
                      : ({1'b0, acc} + {1'b0, operand});
  assign result = sum9[7:0];

  always_comb begin
    flags                   = '0;
    flags[c8080_pkg::FLAG_Z] = (sum9[7:0] == 8'h00);
    flags[c8080_pkg::FLAG_S] = sum9[7];
    flags[c8080_pkg::FLAG_P] = ~^sum9[7:0];
    flags[c8080_pkg::FLAG_C] = sum9[8];
  end

endmodule

// File: rtl/c8080_exec.sv
// ----------------------------------------------------------------------------
// c8080_exec
// Decode and execute of one instruction against the current register state;
// produces the next state and the stack write / fault status.
// ----------------------------------------------------------------------------
module c8080_exec (
  input  c8080_pkg::arch_state_t  st,
  input  c8080_pkg::in_payload_t  item,
  output c8080_pkg::arch_state_t  st_nxt,
  output c8080_pkg::exec_status_t status
);

  logic [2:0]  src_sel;
  logic [2:0]  dst_sel;
  logic [7:0]  src_val;
  logic        is_mov;
  logic        is_add;
  logic        is_sub;
  logic        is_imm;
  logic [7:0]  alu_opd;
  logic        alu_sub;
  logic [7:0]  alu_res;
  logic [3:0]  alu_flags;
  logic [15:0] target;
  logic [15:0] pc_p1;
  logic [15:0] pc_p2;
  logic [15:0] pc_p3;
  logic [15:0] sp_m2;

  assign src_sel = item.op_code[2:0];
  assign dst_sel = item.op_code[5:3];
  assign is_mov  = (item.op_code[7:6] == c8080_pkg::GRP_MOV) && (dst_sel != c8080_pkg::REG_M);
  assign is_add  = (item.op_code[7:3] == c8080_pkg::GRP_ADD);
  assign is_sub  = (item.op_code[7:3] == c8080_pkg::GRP_SUB);
  assign is_imm  = (item.op_code == c8080_pkg::OP_ADI) || (item.op_code == c8080_pkg::OP_SUI);
  assign target  = {item.imm_high, item.imm_low};
  assign pc_p1   = st.pc + 16'd1;
  assign pc_p2   = st.pc + 16'd2;
  assign pc_p3   = st.pc + 16'd3;
  assign sp_m2   = st.sp - 16'd2;

  always_comb begin
    unique case (src_sel)
      c8080_pkg::REG_B: src_val = st.b;
      c8080_pkg::REG_C: src_val = st.c;
      c8080_pkg::REG_D: src_val = st.d;
      c8080_pkg::REG_E: src_val = st.e;
      c8080_pkg::REG_H: src_val = st.h;
      c8080_pkg::REG_L: src_val = st.l;
      c8080_pkg::REG_M: src_val = item.mem_byte;
      c8080_pkg::REG_A: src_val = st.a;
      default:          src_val = st.a;
    endcase
  end

  assign alu_opd = is_imm ? item.imm_low : src_val;
  assign alu_sub = is_sub || (item.op_code == c8080_pkg::OP_SUI);

  c8080_alu u_alu (
    .acc     (st.a),
    .operand (alu_opd),
    .sub     (alu_sub),
    .result  (alu_res),
    .flags   (alu_flags)
  );

  always_comb begin
    st_nxt = st;
    status = '0;
    priority if (is_mov) begin
      st_nxt.pc = pc_p1;
      unique case (dst_sel)
        c8080_pkg::REG_B: st_nxt.b = src_val;
        c8080_pkg::REG_C: st_nxt.c = src_val;
        c8080_pkg::REG_D: st_nxt.d = src_val;
        c8080_pkg::REG_E: st_nxt.e = src_val;
        c8080_pkg::REG_H: st_nxt.h = src_val;
        c8080_pkg::REG_L: st_nxt.l = src_val;
        c8080_pkg::REG_A: st_nxt.a = src_val;
        default: ;
      endcase
    end else if (is_add || is_sub) begin
      st_nxt.pc    = pc_p1;
      st_nxt.a     = alu_res;
      st_nxt.flags = alu_flags;
    end else begin
      unique case (item.op_code)
        c8080_pkg::OP_NOP: st_nxt.pc = pc_p1;
        c8080_pkg::OP_LXIB: begin
          st_nxt.c  = item.imm_low;
          st_nxt.b  = item.imm_high;
          st_nxt.pc = pc_p3;
        end
        c8080_pkg::OP_ADI, c8080_pkg::OP_SUI: begin
          st_nxt.a     = alu_res;
          st_nxt.flags = alu_flags;
          st_nxt.pc    = pc_p2;
        end
        c8080_pkg::OP_JMP: st_nxt.pc = target;
        c8080_pkg::OP_JNZ: st_nxt.pc = !st.flags[c8080_pkg::FLAG_Z] ? target : pc_p3;
        c8080_pkg::OP_JZ:  st_nxt.pc =  st.flags[c8080_pkg::FLAG_Z] ? target : pc_p3;
        c8080_pkg::OP_JNC: st_nxt.pc = !st.flags[c8080_pkg::FLAG_C] ? target : pc_p3;
        c8080_pkg::OP_JC:  st_nxt.pc =  st.flags[c8080_pkg::FLAG_C] ? target : pc_p3;
        c8080_pkg::OP_JP:  st_nxt.pc = !st.flags[c8080_pkg::FLAG_S] ? target : pc_p3;
        c8080_pkg::OP_CALL: begin
          st_nxt.sp      = sp_m2;
          st_nxt.pc      = target;
          status.wr_en   = 1'b1;
          status.wr_addr = sp_m2;
          status.wr_word = pc_p3;
        end
        c8080_pkg::OP_RET: begin
          st_nxt.pc = item.stack_word;
          st_nxt.sp = st.sp + 16'd2;
        end
        // Unimplemented opcode: leave state untouched
        default: status.fault = 1'b1;
      endcase
    end
  end

endmodule

// File: rtl/cpu_8080_subset_step.sv
// ----------------------------------------------------------------------------
// cpu_8080_subset_step
// Executes one 8080 subset instruction per item and reports the full
// register state after it.
// ----------------------------------------------------------------------------
// Each accepted item is one instruction with its operand bytes, the byte at
// HL and the word at SP already fetched. The block takes one instruction per
// clock cycle while the receiver keeps up; an accepted item is held in the
// input register, then executed combinationally into the result register once
// that is free, and transfers when the receiver is ready. The register state
// is written at the same edge that loads the result register, so consecutive
// instructions see each other's results with no gap. Unimplemented opcodes
// raise fault and change nothing; CALL reports a 16-bit stack write that the
// user performs.
module cpu_8080_subset_step (
  input  logic             clk,
  input  logic             rst_n,
  c8080_in_if.sink         in_ch,
  c8080_out_if.source      out_ch
);

  c8080_pkg::in_payload_t  item_r;
  logic                    item_vld_r;
  c8080_pkg::arch_state_t  state_r;
  c8080_pkg::arch_state_t  state_nxt;
  c8080_pkg::exec_status_t ex_status;
  c8080_pkg::out_payload_t out_r;
  c8080_pkg::out_payload_t out_nxt;
  logic                    out_vld_r;
  logic                    advance;

  // Move the held instruction into the result register when it is free
  assign advance     = item_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !item_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.op_code    <= in_ch.op_code;
      item_r.imm_low    <= in_ch.imm_low;
      item_r.imm_high   <= in_ch.imm_high;
      item_r.mem_byte   <= in_ch.mem_byte;
      item_r.stack_word <= in_ch.stack_word;
    end
  end

  c8080_exec u_exec (
    .st     (state_r),
    .item   (item_r),
    .st_nxt (state_nxt),
    .status (ex_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    out_nxt.next_pc      = state_nxt.pc;
    out_nxt.acc_value    = state_nxt.a;
    out_nxt.flag_bits    = state_nxt.flags;
    out_nxt.pair_bc      = {state_nxt.b, state_nxt.c};
    out_nxt.pair_de      = {state_nxt.d, state_nxt.e};
    out_nxt.pair_hl      = {state_nxt.h, state_nxt.l};
    out_nxt.stack_ptr    = state_nxt.sp;
    out_nxt.write_enable = ex_status.wr_en;
    out_nxt.write_addr   = ex_status.wr_addr;
    out_nxt.write_word   = ex_status.wr_word;
    out_nxt.fault        = ex_status.fault;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.next_pc      = out_r.next_pc;
  assign out_ch.acc_value    = out_r.acc_value;
  assign out_ch.flag_bits    = out_r.flag_bits;
  assign out_ch.pair_bc      = out_r.pair_bc;
  assign out_ch.pair_de      = out_r.pair_de;
  assign out_ch.pair_hl      = out_r.pair_hl;
  assign out_ch.stack_ptr    = out_r.stack_ptr;
  assign out_ch.write_enable = out_r.write_enable;
  assign out_ch.write_addr   = out_r.write_addr;
  assign out_ch.write_word   = out_r.write_word;
  assign out_ch.fault        = out_r.fault;

`ifndef SYNTH
  // A faulting instruction leaves the whole register state as it was
  a_fault_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    advance && ex_status.fault |=> state_r == $past(state_r))
    else $error("fault instruction changed state");

  // A stack write always targets the reported stack pointer
  a_write_at_sp: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.write_enable |-> out_r.write_addr == out_r.stack_ptr && !out_r.fault)
    else $error("stack write address differs from stack pointer");

  // Every executed instruction produces a result on the next cycle
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r && out_r.next_pc == state_r.pc)
    else $error("executed instruction has no matching result");
`endif

endmodule
